FILE: rtl/core/rebs_pkg.sv
// Shared constants, codes and the packet planning function of the redundant
// event batch sender.
// No dependencies; imported by redundant_event_batch_sender_top.
package rebs_pkg;

    // Sizes of the history store and of one flush.
    localparam int HIST_DEPTH     = 32;
    localparam int EVENT_BITS     = 64;
    localparam int MAX_PKT_EVENTS = 16;
    localparam int MAX_RESULTS    = 48;

    localparam int IDX_W  = $clog2(HIST_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LEN_W  = $clog2(MAX_RESULTS + MAX_PKT_EVENTS + 1);
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 64;

    // Configuration register widths, limits and reset values.
    localparam int RED_W      = 3;
    localparam int BATCH_W    = 4;
    localparam int REPEAT_W   = 4;
    localparam int INTERVAL_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [RED_W-1:0]      RED_LIMIT        = 3'd4;
    localparam logic [BATCH_W-1:0]    BATCH_LIMIT      = 4'd8;
    localparam logic [RED_W-1:0]      RED_RESET        = 3'd3;
    localparam logic [BATCH_W-1:0]    BATCH_RESET      = 4'd8;
    localparam logic [REPEAT_W-1:0]   REPEAT_RESET     = 4'd3;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 32'd16000;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_QUEUE = 2'd0,
        OP_FLUSH = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REDUNDANCY      = 2'd0,
        CFG_BATCH_MAX       = 2'd1,
        CFG_REPEAT_COUNT    = 2'd2,
        CFG_REPEAT_INTERVAL = 2'd3
    } cfg_idx_t;

    // One planned packet: history positions from..upto-1.
    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] from;
        logic [CNT_W-1:0] upto;
        logic [CNT_W-1:0] batch;
        logic [LEN_W-1:0] k_after;
    } plan_t;

    // Plans the next packet of a flush from the unsent count and the number
    // of results already given out. The packet is refused when nothing is
    // unsent or when it would overrun the result budget.
    function automatic plan_t plan_packet(
        input logic [CNT_W-1:0]   held,
        input logic [CNT_W-1:0]   unsent,
        input logic [RED_W-1:0]   red,
        input logic [BATCH_W-1:0] bm,
        input logic [LEN_W-1:0]   k
    );
        plan_t            p;
        logic [CNT_W-1:0] new_from;
        logic [CNT_W-1:0] red_c;
        logic [CNT_W-1:0] batch;
        logic [LEN_W-1:0] n;
        logic [LEN_W:0]   total;
        new_from = held - unsent;
        red_c    = (new_from < CNT_W'(red)) ? new_from : CNT_W'(red);
        batch    = (unsent < CNT_W'(bm)) ? unsent : CNT_W'(bm);
        n        = LEN_W'(red_c) + LEN_W'(batch);
        if (n > LEN_W'(MAX_PKT_EVENTS))
        begin
            n = LEN_W'(MAX_PKT_EVENTS);
        end
        total     = (LEN_W+1)'(k) + (LEN_W+1)'(n);
        p.ok      = (unsent != '0) && (total <= (LEN_W+1)'(MAX_RESULTS));
        p.from    = new_from - red_c;
        p.upto    = p.from + CNT_W'(n);
        p.batch   = batch;
        p.k_after = total[LEN_W-1:0];
        return p;
    endfunction

endpackage

FILE: rtl/core/redundant_event_batch_sender_top.sv
// Redundant event batch sender: history ring memory, queue update logic and
// the flush sequencer that walks the memory one event per cycle.
// Depends on rebs_pkg.
//
// A queue or clear beat leaves busy low. A flush that sends results keeps
// busy high while it reads them, at most 48 results, since the single
// read port of the history memory yields one event a cycle; each result
// appears on the result ports in the cycle after its read, marked by a
// one-cycle result_valid strobe that the receiver cannot hold off. A flush
// with nothing to send leaves busy low. Configuration writes are always
// ready and should only be made while busy is low and no result is pending.
module redundant_event_batch_sender_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       operation,
    input  logic [63:0]                      event_word,
    input  logic [63:0]                      now_us,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rebs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,
    output logic                             result_valid,
    output logic [63:0]                      out_event,
    output logic [31:0]                      sequence_res,
    output logic                             packet_first,
    output logic                             packet_last,
    output logic                             last
);
    import rebs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Configuration registers.
    logic [RED_W-1:0]      redundancy_reg;
    logic [BATCH_W-1:0]    batch_max_reg;
    logic [REPEAT_W-1:0]   repeat_count_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // History bookkeeping.
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      oldest_reg, oldest_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [CNT_W-1:0]      unsent_reg, unsent_next;
    logic [SEQ_W-1:0]      next_seq_reg, next_seq_next;
    logic [REPEAT_W-1:0]   repeats_reg, repeats_next;
    logic [TIME_W-1:0]     last_send_reg, last_send_next;

    // Flush sequencer.
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      upto_reg, upto_next;
    logic [LEN_W-1:0]      k_reg, k_next;
    logic                  first_reg, first_next;

    // Result stage, aligned with the memory read data.
    logic                  res_valid_reg, res_valid_next;
    logic [SEQ_W-1:0]      res_seq_reg, res_seq_next;
    logic                  res_first_reg, res_first_next;
    logic                  res_plast_reg, res_plast_next;
    logic                  res_last_reg, res_last_next;

    // History memory.
    logic [EVENT_BITS-1:0] hist_mem [HIST_DEPTH];
    logic [EVENT_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_en;

    // Decoded handshake and effective configuration.
    logic                  accept;
    logic [RED_W-1:0]      red_eff;
    logic [BATCH_W-1:0]    bm_eff;

    // Queue update terms.
    logic                  full;
    logic [IDX_W-1:0]      oldest_q;
    logic [CNT_W-1:0]      held_q;
    logic [CNT_W-1:0]      unsent_q;
    logic [CNT_W-1:0]      held_a;
    logic [CNT_W-1:0]      unsent_a;
    logic [LEN_W-1:0]      keep;
    logic [LEN_W-1:0]      sent;
    logic [LEN_W-1:0]      excess;
    logic [LEN_W-1:0]      spare;
    logic [LEN_W-1:0]      trim;

    // Flush terms.
    logic [TIME_W-1:0]     elapsed;
    logic                  resend_due;
    logic [CNT_W-1:0]      tail_len;
    plan_t                 plan_first;
    plan_t                 plan_more;
    logic                  pkt_end;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Out-of-range settings are clamped where they are used.
    always_comb
    begin
        red_eff = (redundancy_reg > RED_LIMIT) ? RED_LIMIT : redundancy_reg;
        if (batch_max_reg == '0)
        begin
            bm_eff = BATCH_W'(1);
        end
        else
        begin
            bm_eff = (batch_max_reg > BATCH_LIMIT) ? BATCH_LIMIT : batch_max_reg;
        end
    end

    // Queue: make room on a full store, append, then trim sent entries
    // beyond the keep depth while more than the redundancy of sent ones stay.
    always_comb
    begin
        full     = (held_reg == CNT_W'(HIST_DEPTH));
        oldest_q = full ? oldest_reg + IDX_W'(1) : oldest_reg;
        held_q   = full ? held_reg - CNT_W'(1) : held_reg;
        unsent_q = (unsent_reg > held_q) ? held_q : unsent_reg;
        wr_addr  = oldest_q + held_q[IDX_W-1:0];
        held_a   = held_q + CNT_W'(1);
        unsent_a = (unsent_q < held_a) ? unsent_q + CNT_W'(1) : unsent_q;
        keep     = LEN_W'(red_eff) + LEN_W'({bm_eff, 1'b0});
        sent     = LEN_W'(held_a - unsent_a);
        excess   = LEN_W'(held_a) - keep;
        spare    = sent - LEN_W'(red_eff);
        if ((LEN_W'(held_a) > keep) && (sent > LEN_W'(red_eff)))
        begin
            trim = (excess < spare) ? excess : spare;
        end
        else
        begin
            trim = '0;
        end
    end

    // Flush planning. The tail resend is at most the redundancy limit long,
    // which is always inside one packet.
    always_comb
    begin
        elapsed    = now_us - last_send_reg;
        resend_due = (repeats_reg != '0) && (elapsed >= TIME_W'(interval_reg));
        tail_len   = (held_reg < CNT_W'(red_eff)) ? held_reg : CNT_W'(red_eff);
        plan_first = plan_packet(held_reg, unsent_reg, red_eff, bm_eff, '0);
        plan_more  = plan_packet(held_reg, unsent_reg, red_eff, bm_eff, k_reg);
        pkt_end    = (cur_reg + CNT_W'(1) == upto_reg);
        rd_addr    = oldest_reg + cur_reg[IDX_W-1:0];
    end

    // Next state of the sequencer and the bookkeeping.
    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        unsent_next    = unsent_reg;
        next_seq_next  = next_seq_reg;
        repeats_next   = repeats_reg;
        last_send_next = last_send_reg;
        cur_next       = cur_reg;
        upto_next      = upto_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        res_valid_next = 1'b0;
        res_seq_next   = res_seq_reg;
        res_first_next = res_first_reg;
        res_plast_next = res_plast_reg;
        res_last_next  = res_last_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(operation))
                        OP_QUEUE:
                        begin
                            wr_en         = 1'b1;
                            oldest_next   = oldest_q + trim[IDX_W-1:0];
                            held_next     = held_a - CNT_W'(trim);
                            unsent_next   = unsent_a;
                            next_seq_next = next_seq_reg + SEQ_W'(1);
                        end
                        OP_FLUSH:
                        begin
                            if (held_reg != '0)
                            begin
                                if (unsent_reg != '0)
                                begin
                                    repeats_next   = repeat_count_reg;
                                    last_send_next = now_us;
                                    if (plan_first.ok)
                                    begin
                                        cur_next    = plan_first.from;
                                        upto_next   = plan_first.upto;
                                        unsent_next = unsent_reg - plan_first.batch;
                                        k_next      = plan_first.k_after;
                                        first_next  = 1'b1;
                                        state_next  = ST_EMIT;
                                    end
                                end
                                else if (resend_due)
                                begin
                                    repeats_next   = repeats_reg - REPEAT_W'(1);
                                    last_send_next = now_us;
                                    if (tail_len != '0)
                                    begin
                                        cur_next   = held_reg - tail_len;
                                        upto_next  = held_reg;
                                        first_next = 1'b1;
                                        state_next = ST_EMIT;
                                    end
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            oldest_next    = '0;
                            held_next      = '0;
                            unsent_next    = '0;
                            next_seq_next  = '0;
                            repeats_next   = '0;
                            last_send_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                // One read per cycle; the side fields ride with the read.
                res_valid_next = 1'b1;
                res_seq_next   = next_seq_reg - SEQ_W'(held_reg - cur_reg);
                res_first_next = first_reg;
                res_plast_next = pkt_end;
                res_last_next  = pkt_end && !plan_more.ok;
                if (pkt_end)
                begin
                    if (plan_more.ok)
                    begin
                        cur_next    = plan_more.from;
                        upto_next   = plan_more.upto;
                        unsent_next = unsent_reg - plan_more.batch;
                        k_next      = plan_more.k_after;
                        first_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cur_next   = cur_reg + CNT_W'(1);
                    first_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            oldest_reg       <= '0;
            held_reg         <= '0;
            unsent_reg       <= '0;
            next_seq_reg     <= '0;
            repeats_reg      <= '0;
            last_send_reg    <= '0;
            cur_reg          <= '0;
            upto_reg         <= '0;
            k_reg            <= '0;
            first_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
            redundancy_reg   <= RED_RESET;
            batch_max_reg    <= BATCH_RESET;
            repeat_count_reg <= REPEAT_RESET;
            interval_reg     <= INTERVAL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            unsent_reg    <= unsent_next;
            next_seq_reg  <= next_seq_next;
            repeats_reg   <= repeats_next;
            last_send_reg <= last_send_next;
            cur_reg       <= cur_next;
            upto_reg      <= upto_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_REDUNDANCY:      redundancy_reg   <= cfg_data[RED_W-1:0];
                    CFG_BATCH_MAX:       batch_max_reg    <= cfg_data[BATCH_W-1:0];
                    CFG_REPEAT_COUNT:    repeat_count_reg <= cfg_data[REPEAT_W-1:0];
                    CFG_REPEAT_INTERVAL: interval_reg     <= cfg_data[INTERVAL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result side fields carry no reset.
    always_ff @(posedge clk)
    begin
        res_seq_reg   <= res_seq_next;
        res_first_reg <= res_first_next;
        res_plast_reg <= res_plast_next;
        res_last_reg  <= res_last_next;
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= event_word[EVENT_BITS-1:0];
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    assign result_valid = res_valid_reg;
    assign out_event    = 64'(rd_data_reg);
    assign sequence_res = res_seq_reg;
    assign packet_first = res_first_reg;
    assign packet_last  = res_plast_reg;
    assign last         = res_last_reg;

    // The unsent events are always a part of those held.
    a_unsent_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (unsent_reg <= held_reg) && (held_reg <= CNT_W'(HIST_DEPTH)))
        else $error("unsent count exceeds held count or store depth");

    // A result only follows a cycle of the flush sequencer.
    a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result without a preceding read");

    // The final result of a flush also closes its packet.
    a_last_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> packet_last)
        else $error("final result does not close a packet");

    // A queue beat never starts the sequencer.
    a_queue_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_QUEUE)) |=> !busy)
        else $error("queue beat left the block busy");

endmodule
